### design/plst_pkg.sv
// Shared constants and types for the positional list store.
package plst_pkg;

   localparam int CAPACITY = 64;

   localparam int LEN_W  = 7;
   localparam int ADDR_W = 6;
   localparam int POS_W  = 6;
   localparam int DATA_W = 32;
   localparam int DEPTH  = 64;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

   typedef enum logic [2:0] {
      K_PUSH_FRONT = 3'd0,
      K_PUSH_BACK  = 3'd1,
      K_POP_FRONT  = 3'd2,
      K_POP_BACK   = 3'd3,
      K_INSERT_AT  = 3'd4,
      K_REMOVE_AT  = 3'd5,
      K_CLEAR      = 3'd6,
      K_READ_ALL   = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      S_OK     = 2'd0,
      S_EMPTY  = 2'd1,
      S_BADPOS = 2'd2,
      S_FULL   = 2'd3
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_EXEC      = 7'b0000010,
      ST_SHIFT_RD  = 7'b0000100,
      ST_SHIFT_WR  = 7'b0001000,
      ST_FILL      = 7'b0010000,
      ST_DUMP_RD   = 7'b0100000,
      ST_DUMP_WAIT = 7'b1000000
   } state_type;

   // Insert and remove that move elements finish in ST_FILL, which writes the new value for
   // an insert and then posts the result; see the top level.

endpackage

### design/positional_list_store.sv
// Top level of the positional list store: sequencer, element memory and result register.
//
// The list lives in a 64-entry single-port-write, registered-read memory used as a ring
// buffer, so a push at either end costs one memory write and a pop none. ST_IDLE takes
// the command; ST_EXEC then carries it out and posts the result once the output is free.
// Insert and remove move the elements behind the target position one entry at a time,
// each moved element taking a registered read in ST_SHIFT_RD and then the write back in
// ST_SHIFT_WR, and ST_FILL ends the command. Read-all reads each element in ST_DUMP_RD and
// posts it from ST_DUMP_WAIT, which waits while the result side stalls. One command is
// worked on at a time, and a new command is taken while the previous result still waits
// on the result channel. The memory needs no clearing after reset: only entries below the
// current length are ever read.
module positional_list_store
   import plst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // position [5:0], value [37:6], zero fill [39:38]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // kind [2:0]
   input  logic [2:0]             req_tuser,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // item [31:0], count [38:32], zero fill [39]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // status [1:0]
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   // Element storage, indexed by physical address (head plus logical position).
   logic [DATA_W-1:0] elements_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   state_type           state_ff, state_in;
   kind_type            kind_ff, kind_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [ADDR_W-1:0]   head_ff, head_in;
   logic [LEN_W-1:0]    length_ff, length_in;
   logic [LEN_W-1:0]    idx_ff, idx_in;

   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_item_ff;
   status_type          rsp_status_ff;
   logic                rsp_last_ff;
   logic [LEN_W-1:0]    rsp_count_ff;

   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [DATA_W-1:0]   mem_wdata;
   logic                mem_re;
   logic [ADDR_W-1:0]   mem_raddr;

   logic                post;
   logic [DATA_W-1:0]   post_item;
   status_type          post_status;
   logic                post_last;

   logic                out_free;
   logic                is_empty;
   logic                is_full;
   logic                pos_bad;
   logic [LEN_W-1:0]    pos_ext;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_empty = (length_ff == '0);
   assign is_full  = (length_ff >= CAP_LEN);
   assign pos_ext  = {1'b0, pos_ff};
   assign pos_bad  = (pos_ext >= length_ff);

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      pos_in      = pos_ff;
      value_in    = value_ff;
      head_in     = head_ff;
      length_in   = length_ff;
      idx_in      = idx_ff;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = value_ff;
      mem_re      = 1'b0;
      mem_raddr   = '0;
      post        = 1'b0;
      post_item   = '0;
      post_status = S_OK;
      post_last   = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in  = kind_type'(req_tuser);
               pos_in   = req_tdata[POS_W-1:0];
               value_in = req_tdata[POS_W+DATA_W-1:POS_W];
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               case (kind_ff)
                  K_PUSH_FRONT: begin
                     post     = 1'b1;
                     state_in = ST_IDLE;
                     if (is_full) begin
                        post_status = S_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = head_ff - ADDR_W'(1);
                        head_in   = head_ff - ADDR_W'(1);
                        length_in = length_ff + LEN_W'(1);
                     end
                  end
                  K_PUSH_BACK: begin
                     post     = 1'b1;
                     state_in = ST_IDLE;
                     if (is_full) begin
                        post_status = S_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = head_ff + length_ff[ADDR_W-1:0];
                        length_in = length_ff + LEN_W'(1);
                     end
                  end
                  K_POP_FRONT: begin
                     post     = 1'b1;
                     state_in = ST_IDLE;
                     if (is_empty) begin
                        post_status = S_EMPTY;
                     end else begin
                        head_in   = head_ff + ADDR_W'(1);
                        length_in = length_ff - LEN_W'(1);
                     end
                  end
                  K_POP_BACK: begin
                     post     = 1'b1;
                     state_in = ST_IDLE;
                     if (is_empty) begin
                        post_status = S_EMPTY;
                     end else begin
                        length_in = length_ff - LEN_W'(1);
                     end
                  end
                  K_INSERT_AT: begin
                     if (is_empty) begin
                        post        = 1'b1;
                        post_status = S_EMPTY;
                        state_in    = ST_IDLE;
                     end else if (pos_bad) begin
                        post        = 1'b1;
                        post_status = S_BADPOS;
                        state_in    = ST_IDLE;
                     end else if (is_full) begin
                        post        = 1'b1;
                        post_status = S_FULL;
                        state_in    = ST_IDLE;
                     end else begin
                        // Move the tail up one place, starting at the end.
                        idx_in   = length_ff;
                        state_in = ST_SHIFT_RD;
                     end
                  end
                  K_REMOVE_AT: begin
                     if (is_empty) begin
                        post        = 1'b1;
                        post_status = S_EMPTY;
                        state_in    = ST_IDLE;
                     end else if (pos_bad) begin
                        post        = 1'b1;
                        post_status = S_BADPOS;
                        state_in    = ST_IDLE;
                     end else if (pos_ext + LEN_W'(1) == length_ff) begin
                        // Removing the last element needs no moves.
                        post      = 1'b1;
                        length_in = length_ff - LEN_W'(1);
                        state_in  = ST_IDLE;
                     end else begin
                        idx_in   = pos_ext;
                        state_in = ST_SHIFT_RD;
                     end
                  end
                  K_CLEAR: begin
                     post      = 1'b1;
                     length_in = '0;
                     state_in  = ST_IDLE;
                  end
                  default: begin
                     if (is_empty) begin
                        post        = 1'b1;
                        post_status = S_EMPTY;
                        state_in    = ST_IDLE;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_DUMP_RD;
                     end
                  end
               endcase
            end
         end

         ST_SHIFT_RD: begin
            mem_re = 1'b1;
            if (kind_ff == K_INSERT_AT) begin
               mem_raddr = head_ff + idx_ff[ADDR_W-1:0] - ADDR_W'(1);
            end else begin
               mem_raddr = head_ff + idx_ff[ADDR_W-1:0] + ADDR_W'(1);
            end
            state_in = ST_SHIFT_WR;
         end

         ST_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = head_ff + idx_ff[ADDR_W-1:0];
            mem_wdata = rd_data_ff;
            if (kind_ff == K_INSERT_AT) begin
               idx_in = idx_ff - LEN_W'(1);
               if (idx_ff - LEN_W'(1) == pos_ext) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_SHIFT_RD;
               end
            end else begin
               idx_in = idx_ff + LEN_W'(1);
               if (idx_ff + LEN_W'(2) == length_ff) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_SHIFT_RD;
               end
            end
         end

         ST_FILL: begin
            // Insert drops the new value into the gap; both finish by posting.
            if (kind_ff == K_INSERT_AT) begin
               mem_we    = 1'b1;
               mem_waddr = head_ff + pos_ff;
            end
            if (out_free) begin
               post     = 1'b1;
               state_in = ST_IDLE;
               if (kind_ff == K_INSERT_AT) begin
                  length_in = length_ff + LEN_W'(1);
               end else begin
                  length_in = length_ff - LEN_W'(1);
               end
            end
         end

         ST_DUMP_RD: begin
            mem_re    = 1'b1;
            mem_raddr = head_ff + idx_ff[ADDR_W-1:0];
            state_in  = ST_DUMP_WAIT;
         end

         ST_DUMP_WAIT: begin
            if (out_free) begin
               post      = 1'b1;
               post_item = rd_data_ff;
               post_last = (idx_ff + LEN_W'(1) == length_ff);
               idx_in    = idx_ff + LEN_W'(1);
               if (idx_ff + LEN_W'(1) == length_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DUMP_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Element memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         elements_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= elements_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         length_ff    <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         length_ff <= length_in;
         idx_ff    <= idx_in;
         if (post) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      pos_ff   <= pos_in;
      value_ff <= value_in;
      if (post) begin
         rsp_item_ff   <= post_item;
         rsp_status_ff <= post_status;
         rsp_last_ff   <= post_last;
         rsp_count_ff  <= length_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_item_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The list never holds more than its capacity.
   assert property (@(posedge clock) disable iff (reset) length_ff <= CAP_LEN)
      else $error("list length exceeds capacity");

   // While elements are being moved, the length does not change.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT_RD) |=> $stable(length_ff))
      else $error("length changed in the middle of a move");

   // Read-all only ever addresses positions inside the list.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP_RD || state_ff == ST_DUMP_WAIT) |-> (idx_ff < length_ff))
      else $error("read-all index past the end of the list");

   // A read-all result is the last one exactly when its index reaches the end.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP_WAIT && out_free) |=> (rsp_tlast == (state_ff == ST_IDLE)))
      else $error("read-all last flag out of step with the sequencer");

endmodule
